[rtl/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

  // Capacity of the queue and the widths that follow from it.
  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int IN_DW  = ((VAL_W + 7) / 8) * 8;
  localparam int OUT_DW = ((VAL_W + CNT_W + 7) / 8) * 8;
  localparam int ST_W   = 2;

  typedef logic [CNT_W-1:0]        count_t;
  typedef logic signed [VAL_W-1:0] value_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Input opcode carried in tuser.
  typedef enum logic {
    FN_INSERT = 1'b0,
    FN_REMOVE = 1'b1
  } func_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic rem;
  } cmd_t;

endpackage

[rtl/spq_cell.sv]
`timescale 1ns / 1ps

// One slot of the sorted chain: compare against the broadcast value and
// keep, take the new value, or take a neighbor's entry.
module spq_cell (
  input  logic            clk,
  input  spq_pkg::cmd_t   cmd,
  input  spq_pkg::value_t value,
  input  logic            occ,
  input  logic            left_gt,
  input  spq_pkg::value_t left_entry,
  input  spq_pkg::value_t right_entry,
  output logic            gt,
  output spq_pkg::value_t entry
);

  spq_pkg::value_t entry_r;
  spq_pkg::value_t entry_nxt;

  // An empty slot acts as plus infinity so new values land there.
  assign gt    = !occ || (entry_r > value);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    priority if (cmd.ins && gt) begin
      entry_nxt = left_gt ? left_entry : value;
    end else if (cmd.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[rtl/sorted_priority_queue_core.sv]
`timescale 1ns / 1ps
// Sorted ascending priority queue built as a chain of compare-and-shift cells.
// The result beat appears on the output in the cycle after its input beat is accepted.
// Throughput: one insert or removal per cycle; the single output register
// sets it, and it holds while the downstream side keeps out_tready high.
// Reset (rst_n low, synchronous): the queue empties and the output goes idle.
module sorted_priority_queue_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [spq_pkg::IN_DW-1:0] in_tdata,   // [31:0] value
  input  logic                      in_tuser,   // [0] func
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [spq_pkg::OUT_DW-1:0] out_tdata, // [31:0] removed_value,
                                                // [CNT_W+31:32] entry_count
  output logic [spq_pkg::ST_W-1:0]  out_tuser   // [1:0] status
);

  // Cell chain signals.
  spq_pkg::value_t entries [spq_pkg::DEPTH];
  logic            gts     [spq_pkg::DEPTH];
  logic            occ     [spq_pkg::DEPTH];

  // Queue fill level and output register.
  spq_pkg::count_t  count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  spq_pkg::value_t  rm_val_r, rm_val_nxt;
  spq_pkg::status_t status_r, status_nxt;
  spq_pkg::count_t  cnt_out_r, cnt_out_nxt;

  spq_pkg::cmd_t   cmd;
  spq_pkg::value_t in_value;
  logic            in_accept;
  logic            is_full;
  logic            is_empty;

  // Take a new beat whenever the output slot is free or drains this cycle;
  // refuse beats while reset is held.
  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign in_accept = in_tvalid && in_tready;
  assign in_value  = spq_pkg::value_t'(in_tdata[spq_pkg::VAL_W-1:0]);
  assign is_full   = (count_r == spq_pkg::count_t'(spq_pkg::DEPTH));
  assign is_empty  = (count_r == '0);

  // Broadcast the operation to the chain only when it changes the store.
  assign cmd.ins = in_accept && (spq_pkg::func_t'(in_tuser) == spq_pkg::FN_INSERT) && !is_full;
  assign cmd.rem = in_accept && (spq_pkg::func_t'(in_tuser) == spq_pkg::FN_REMOVE) && !is_empty;

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    localparam spq_pkg::count_t IDX = spq_pkg::count_t'(i);
    // Slots below the fill level hold live values; the rest are free.
    assign occ[i] = (count_r > IDX);
    if (i == 0) begin : g_head
      // Head cell: a value that beats it always lands here.
      spq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .value      (in_value),
        .occ        (occ[i]),
        .left_gt    (1'b0),
        .left_entry (in_value),
        .right_entry(entries[(i + 1) % spq_pkg::DEPTH]),
        .gt         (gts[i]),
        .entry      (entries[i])
      );
    end else if (i == spq_pkg::DEPTH - 1) begin : g_tail
      // Tail cell: nothing shifts in from the right; keep own entry.
      spq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .value      (in_value),
        .occ        (occ[i]),
        .left_gt    (gts[i-1]),
        .left_entry (entries[i-1]),
        .right_entry(entries[i]),
        .gt         (gts[i]),
        .entry      (entries[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .value      (in_value),
        .occ        (occ[i]),
        .left_gt    (gts[i-1]),
        .left_entry (entries[i-1]),
        .right_entry(entries[i+1]),
        .gt         (gts[i]),
        .entry      (entries[i])
      );
    end
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    rm_val_nxt    = rm_val_r;
    status_nxt    = status_r;
    cnt_out_nxt   = cnt_out_r;

    // Drop the result once the downstream side takes it.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_accept) begin
      out_valid_nxt = 1'b1;
      rm_val_nxt    = '0;
      status_nxt    = spq_pkg::ST_OK;
      unique case (spq_pkg::func_t'(in_tuser))
        spq_pkg::FN_INSERT: begin
          if (is_full) begin
            status_nxt = spq_pkg::ST_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        spq_pkg::FN_REMOVE: begin
          if (is_empty) begin
            status_nxt = spq_pkg::ST_EMPTY;
          end else begin
            // Head of the chain is the minimum.
            rm_val_nxt = entries[0];
            count_nxt  = count_r - 1'b1;
          end
        end
        default: begin
          status_nxt = spq_pkg::ST_OK;
        end
      endcase
      cnt_out_nxt = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rm_val_r  <= rm_val_nxt;
    status_r  <= status_nxt;
    cnt_out_r <= cnt_out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = spq_pkg::OUT_DW'({cnt_out_r, rm_val_r});
  assign out_tuser  = status_r;

`ifndef ASSERT_OFF
  // Fill level never passes capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= spq_pkg::count_t'(spq_pkg::DEPTH))
    else $error("queue fill level above capacity");

  // A successful insert raises the fill level by exactly one.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not advance fill level");

  // A full status is only reported with the queue at capacity.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == spq_pkg::ST_FULL) |->
      cnt_out_r == spq_pkg::count_t'(spq_pkg::DEPTH))
    else $error("full status with queue below capacity");

  // The two front cells stay in ascending order.
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > spq_pkg::count_t'(1)) |-> entries[0] <= entries[1])
    else $error("front entries out of order");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  // One operation waiting to go out on the input stream.
  typedef struct {
    spq_pkg::func_t  fn;
    spq_pkg::value_t val;
    bit              drain_first;  // hold this beat back until every result is out
  } queue_op_t;

  // Fields of one result beat, as the queue should report it.
  typedef struct {
    spq_pkg::value_t  removed;
    spq_pkg::status_t status;
    spq_pkg::count_t  count;
  } queue_result_t;

  localparam int RUN_LIMIT_NS = 2_000_000;
  localparam int RAND_BLOCKS  = 33;
  localparam int BLOCK_LEN    = 50;
  localparam int TAIL_CYCLES  = 10;
  localparam int MAX_REPORTS  = 10;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [spq_pkg::IN_DW-1:0]  in_tdata = '0;
  logic                       in_tuser = 1'b0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [spq_pkg::OUT_DW-1:0] out_tdata;
  logic [spq_pkg::ST_W-1:0]   out_tuser;

  sorted_priority_queue_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [31:0] value
    .in_tuser   (in_tuser),   // [0] func
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [31:0] removed_value, [CNT_W+31:32] entry_count
    .out_tuser  (out_tuser)   // [1:0] status
  );

  queue_op_t     pending_ops[$];
  queue_result_t exp_results[$];

  // Shadow copy of the queue contents, kept sorted, front at slot 0.
  spq_pkg::value_t sorted_vals[spq_pkg::DEPTH];
  int              held_cnt = 0;

  int  mismatch_cnt = 0;
  int  fail_cnt = 0;
  bit  in_beat_seen = 1'b0;
  int  burst_left = 1;
  int  gap_left = 0;
  int  rdy_cyc = 0;

  // Free-running clock, 10 ns period.
  initial begin
    forever #5 clk = ~clk;
  end

  // Hold reset low at the start, then release it for good.
  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Work out the result of one operation and advance the shadow queue.
  function automatic queue_result_t predict_queue_op(input spq_pkg::func_t fn,
                                                     input spq_pkg::value_t v);
    queue_result_t r;
    int pos;
    r.removed = '0;
    r.status  = spq_pkg::ST_OK;
    if (fn == spq_pkg::FN_INSERT) begin
      if (held_cnt >= spq_pkg::DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // Equal values stay ahead of the newcomer, so arrival order holds.
        pos = 0;
        while (pos < held_cnt && sorted_vals[pos] <= v) pos++;
        for (int k = held_cnt; k > pos; k--) sorted_vals[k] = sorted_vals[k-1];
        sorted_vals[pos] = v;
        held_cnt++;
      end
    end else begin
      if (held_cnt == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.removed = sorted_vals[0];
        for (int k = 1; k < held_cnt; k++) sorted_vals[k-1] = sorted_vals[k];
        held_cnt--;
      end
    end
    r.count = spq_pkg::count_t'(held_cnt);
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    mismatch_cnt++;
    fail_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("mismatch on %s at %0t: expected %0h, got %0h", field, $realtime, exp_v, act_v);
  endtask

  // Receiver: cycle through always-ready, coin-flip, mostly-stalled and a
  // fixed stall pattern, each for a stretch of equal length, in turn.
  function automatic logic pick_ready(input int cyc);
    logic [6:0] stall_pat;
    stall_pat = 7'b1011001;
    case ((cyc / 256) % 4)
      0: return 1'b1;
      1: return logic'($urandom_range(0, 1));
      2: return ($urandom_range(0, 3) == 0);
      default: return stall_pat[cyc % 7];
    endcase
  endfunction

  // Drive both channels away from the sampling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      rdy_cyc++;
      out_tready <= pick_ready(rdy_cyc);
      if (in_tvalid && !in_beat_seen) begin
        // Hold the beat that has not been taken yet.
      end else if (pending_ops.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (pending_ops[0].drain_first && exp_results.size() != 0) begin
        // Pause until the queue has delivered every outstanding result.
        in_tvalid <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_ops[0].fn;
        in_tdata  <= spq_pkg::IN_DW'(pending_ops[0].val);
        burst_left--;
        if (burst_left <= 0) begin
          // End the burst; a quarter of them run straight into the next one.
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Sample both channels at the rising edge: check results, predict inputs.
  always @(posedge clk) begin
    queue_result_t r;
    in_beat_seen = 1'b0;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (exp_results.size() == 0) begin
          fail_cnt++;
          $display("unexpected result beat at %0t: tdata %0h tuser %0h",
                   $realtime, out_tdata, out_tuser);
        end else begin
          r = exp_results.pop_front();
          if (out_tdata[spq_pkg::VAL_W-1:0] !== r.removed)
            note_mismatch("removed_value", 64'(r.removed),
                          64'(out_tdata[spq_pkg::VAL_W-1:0]));
          if (out_tuser !== r.status)
            note_mismatch("status", 64'(r.status), 64'(out_tuser));
          if (out_tdata[spq_pkg::VAL_W+spq_pkg::CNT_W-1:spq_pkg::VAL_W] !== r.count)
            note_mismatch("entry_count", 64'(r.count),
                          64'(out_tdata[spq_pkg::VAL_W+spq_pkg::CNT_W-1:spq_pkg::VAL_W]));
          if ((out_tdata >> (spq_pkg::VAL_W + spq_pkg::CNT_W)) !== '0)
            note_mismatch("tdata padding", 64'd0,
                          64'(out_tdata >> (spq_pkg::VAL_W + spq_pkg::CNT_W)));
        end
      end
      if (in_tvalid && in_tready) begin
        in_beat_seen = 1'b1;
        exp_results.push_back(predict_queue_op(spq_pkg::func_t'(in_tuser),
                              spq_pkg::value_t'(in_tdata[spq_pkg::VAL_W-1:0])));
        void'(pending_ops.pop_front());
      end
    end
  end

  task automatic add_op(input spq_pkg::func_t fn, input spq_pkg::value_t v, input bit drain);
    queue_op_t op;
    op.fn = fn;
    op.val = v;
    op.drain_first = drain;
    pending_ops.push_back(op);
  endtask

  // Values from a narrow band (many ties), the full range, or the edges.
  function automatic spq_pkg::value_t pick_value(input int mode);
    case (mode)
      0: return spq_pkg::value_t'(int'($urandom_range(0, 8)) - 4);
      1: return spq_pkg::value_t'($urandom);
      default: begin
        case ($urandom_range(0, 6))
          0: return spq_pkg::value_t'(32'h8000_0000);
          1: return spq_pkg::value_t'(32'h7fff_ffff);
          2: return spq_pkg::value_t'(32'h0);
          3: return spq_pkg::value_t'(32'hffff_ffff);
          4: return spq_pkg::value_t'(32'h8000_0001);
          5: return spq_pkg::value_t'(32'h7fff_fffe);
          default: return spq_pkg::value_t'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic build_stimulus();
    int ins_pct;
    int vmode;
    // Directed: removal from empty, the value extremes, ties, filling to
    // capacity, inserts into a full queue, then removals mixed with an insert.
    add_op(spq_pkg::FN_REMOVE, spq_pkg::value_t'(32'h1234_5678), 1'b0);
    add_op(spq_pkg::FN_INSERT, spq_pkg::value_t'(32'h7fff_ffff), 1'b0);
    add_op(spq_pkg::FN_INSERT, spq_pkg::value_t'(32'h8000_0000), 1'b0);
    add_op(spq_pkg::FN_INSERT, spq_pkg::value_t'(32'h0), 1'b0);
    add_op(spq_pkg::FN_INSERT, spq_pkg::value_t'(32'hffff_ffff), 1'b0);
    add_op(spq_pkg::FN_INSERT, spq_pkg::value_t'(5), 1'b0);
    add_op(spq_pkg::FN_INSERT, spq_pkg::value_t'(5), 1'b0);
    for (int i = 0; i < spq_pkg::DEPTH - 6; i++)
      add_op(spq_pkg::FN_INSERT, spq_pkg::value_t'(int'(i * 37) - 150), 1'b0);
    add_op(spq_pkg::FN_INSERT, spq_pkg::value_t'(32'h8000_0000), 1'b0);
    add_op(spq_pkg::FN_INSERT, spq_pkg::value_t'(1), 1'b0);
    add_op(spq_pkg::FN_REMOVE, spq_pkg::value_t'(32'hffff_ffff), 1'b0);
    add_op(spq_pkg::FN_REMOVE, spq_pkg::value_t'(32'h0), 1'b0);
    add_op(spq_pkg::FN_INSERT, spq_pkg::value_t'(32'h7fff_ffff), 1'b0);
    add_op(spq_pkg::FN_REMOVE, spq_pkg::value_t'(32'h0), 1'b0);

    // Random: blocks that lean toward filling, balancing or draining, so the
    // fill level sweeps from empty to full many times.
    for (int b = 0; b < RAND_BLOCKS; b++) begin
      case ($urandom_range(0, 2))
        0: ins_pct = 85;
        1: ins_pct = 50;
        default: ins_pct = 15;
      endcase
      vmode = $urandom_range(0, 2);
      for (int i = 0; i < BLOCK_LEN; i++) begin
        if ($urandom_range(1, 100) <= ins_pct)
          add_op(spq_pkg::FN_INSERT, pick_value(vmode),
                 (i == 0) && (b == 0 || b == 11 || b == 22));
        else
          add_op(spq_pkg::FN_REMOVE, spq_pkg::value_t'($urandom),
                 (i == 0) && (b == 0 || b == 11 || b == 22));
      end
    end
  endtask

  // Run the stimulus, drain the results and decide the outcome.
  initial begin
    build_stimulus();
    while (!rst_n) @(posedge clk);
    while (pending_ops.size() != 0) @(posedge clk);
    while (exp_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && exp_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

endmodule
